// ----- rtl/aapb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aapb_pkg
// Shared types, character codes, register indexes and status codes of the
// any-base string-to-integer parser.
// ----------------------------------------------------------------------------
package aapb_pkg;

	localparam int MAX_RADIX   = 16;
	localparam int NUM_SYMS    = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	// register indexes
	localparam logic [1:0] REG_SYM_LO = 2'd0;
	localparam logic [1:0] REG_SYM_HI = 2'd1;
	localparam logic [1:0] REG_RADIX  = 2'd2;

	localparam logic [63:0] SYM_LO_RESET = 64'h3736_3534_3332_3130;
	localparam logic [63:0] SYM_HI_RESET = 64'h0000_0000_0000_3938;
	localparam logic [4:0]  RADIX_RESET  = 5'd10;

	// result status
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_ALPH = 2'd1;
	localparam logic [1:0] ST_BAD_CHAR = 2'd2;

	// character codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_WS_LO = 8'd9;
	localparam logic [7:0] CH_WS_HI = 8'd13;

	typedef enum logic [2:0] {
		PH_SPACE = 3'b001,
		PH_SIGN  = 3'b010,
		PH_DIGIT = 3'b100
	} phase_t;

	typedef struct packed {
		logic [NUM_SYMS-1:0][7:0] sym;
		logic [4:0]               radix;
		logic                     alph_ok;
	} cfg_t;

	// classified character
	typedef struct packed {
		logic       is_end;
		logic       is_ws;
		logic       is_plus;
		logic       is_minus;
		logic       hit;
		logic [3:0] digit;
	} tok_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_WS_LO) && (c <= CH_WS_HI));
	endfunction

endpackage

// ----- rtl/aapb_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aapb interfaces
// Valid/ready channels: character input, result output, register writes.
// ----------------------------------------------------------------------------
interface aapb_ch_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;

	modport source (output valid, output ch, input ready);
	modport sink (input valid, input ch, output ready);
endinterface

interface aapb_res_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	logic [1:0]         status;

	modport source (output valid, output value, output status, input ready);
	modport sink (input valid, input value, input status, output ready);
endinterface

interface aapb_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [63:0] wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

// ----- rtl/aapb_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aapb_cfg
// Alphabet and radix registers, with a registered alphabet validity check.
// ----------------------------------------------------------------------------
module aapb_cfg (
	input  logic          clk,
	input  logic          arst_n,
	aapb_cfg_if.sink      cfg,
	output aapb_pkg::cfg_t cfg_o
);
	import aapb_pkg::*;

	logic [NUM_SYMS-1:0][7:0] sym_q;
	logic [4:0]               radix_q;
	logic                     alph_ok_q;
	logic                     ok;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_q[7:0]  <= SYM_LO_RESET;
			sym_q[15:8] <= SYM_HI_RESET;
			radix_q     <= RADIX_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_SYM_LO: sym_q[7:0]  <= cfg.wdata;
				REG_SYM_HI: sym_q[15:8] <= cfg.wdata;
				REG_RADIX:  radix_q     <= cfg.wdata[4:0];
				default: ;
			endcase
		end
	end

	// parallel check of every symbol in use and every pair
	always_comb begin
		ok = (radix_q >= 5'd2) && (radix_q <= 5'(MAX_RADIX));
		for (int i = 0; i < NUM_SYMS; i++) begin
			if (5'(i) < radix_q) begin
				if ((sym_q[i] == CH_NUL) || (sym_q[i] == CH_PLUS) ||
				    (sym_q[i] == CH_MINUS) || is_ws(sym_q[i]))
					ok = 1'b0;
				for (int j = i + 1; j < NUM_SYMS; j++) begin
					if ((5'(j) < radix_q) && (sym_q[j] == sym_q[i]))
						ok = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alph_ok_q <= 1'b1;
		end else begin
			alph_ok_q <= ok;
		end
	end

	assign cfg_o.sym     = sym_q;
	assign cfg_o.radix   = radix_q;
	assign cfg_o.alph_ok = alph_ok_q;

endmodule

// ----- rtl/aapb_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aapb_front
// Accepts characters and classifies them: end, whitespace, sign, digit index.
// ----------------------------------------------------------------------------
module aapb_front (
	aapb_ch_if.sink        char_in,
	input  aapb_pkg::cfg_t cfg_i,
	input  logic           full_i,
	output logic           push_o,
	output aapb_pkg::tok_t tok_o
);
	import aapb_pkg::*;

	logic       hit;
	logic [3:0] digit;

	assign char_in.ready = !full_i;
	assign push_o        = char_in.valid && !full_i;

	// lowest matching symbol wins
	always_comb begin
		hit   = 1'b0;
		digit = '0;
		for (int k = NUM_SYMS - 1; k >= 0; k--) begin
			if ((5'(k) < cfg_i.radix) && (cfg_i.sym[k] == char_in.ch)) begin
				hit   = 1'b1;
				digit = 4'(k);
			end
		end
	end

	assign tok_o.is_end   = (char_in.ch == CH_NUL);
	assign tok_o.is_ws    = is_ws(char_in.ch);
	assign tok_o.is_plus  = (char_in.ch == CH_PLUS);
	assign tok_o.is_minus = (char_in.ch == CH_MINUS);
	assign tok_o.hit      = hit;
	assign tok_o.digit    = digit;

endmodule

// ----- rtl/aapb_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aapb_queue
// Short register queue of classified characters between front and back.
// ----------------------------------------------------------------------------
module aapb_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_i,
	input  aapb_pkg::tok_t tok_i,
	output logic           full_o,
	input  logic           pop_i,
	output aapb_pkg::tok_t tok_o,
	output logic           empty_o
);
	import aapb_pkg::*;

	tok_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty_o = (cnt_q == '0);
	assign tok_o   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_i) begin
			mem_q[wr_ptr_q] <= tok_i;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push_i) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop_i) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push_i, pop_i})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- rtl/aapb_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aapb_back
// Parse state machine, multiply-add accumulator and result register.
// ----------------------------------------------------------------------------
module aapb_back (
	input  logic           clk,
	input  logic           arst_n,
	input  aapb_pkg::cfg_t cfg_i,
	input  aapb_pkg::tok_t tok_i,
	input  logic           empty_i,
	output logic           pop_o,
	aapb_res_if.source     res_out
);
	import aapb_pkg::*;

	phase_t             phase_q;
	logic               neg_q;
	logic [31:0]        acc_q;
	logic               bad_q;
	logic               out_valid_q;
	logic signed [31:0] out_value_q;
	logic [1:0]         out_status_q;

	logic        pre_digit;
	logic [1:0]  status;
	logic [31:0] mac;

	assign pop_o = !empty_i && (!tok_i.is_end || !out_valid_q || res_out.ready);

	assign pre_digit = (phase_q == PH_SPACE) || (phase_q == PH_SIGN);
	assign mac = 32'(acc_q * 32'(cfg_i.radix)) + 32'(tok_i.digit);

	always_comb begin
		if (!cfg_i.alph_ok) begin
			status = ST_BAD_ALPH;
		end else if (bad_q) begin
			status = ST_BAD_CHAR;
		end else begin
			status = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SPACE;
			neg_q   <= 1'b0;
			acc_q   <= '0;
			bad_q   <= 1'b0;
		end else if (pop_o) begin
			if (tok_i.is_end) begin
				phase_q <= PH_SPACE;
				neg_q   <= 1'b0;
				acc_q   <= '0;
				bad_q   <= 1'b0;
			end else if (!bad_q) begin
				if ((phase_q == PH_SPACE) && tok_i.is_ws) begin
					phase_q <= PH_SPACE;
				end else if (pre_digit && tok_i.is_minus) begin
					phase_q <= PH_SIGN;
					neg_q   <= !neg_q;
				end else if (pre_digit && tok_i.is_plus) begin
					phase_q <= PH_SIGN;
				end else begin
					phase_q <= PH_DIGIT;
					if (tok_i.hit) begin
						acc_q <= mac;
					end else begin
						bad_q <= 1'b1;
					end
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop_o && tok_i.is_end) begin
			out_valid_q <= 1'b1;
		end else if (res_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_o && tok_i.is_end) begin
			out_status_q <= status;
			if (status != ST_OK) begin
				out_value_q <= '0;
			end else if (neg_q) begin
				out_value_q <= 32'(32'd0 - acc_q);
			end else begin
				out_value_q <= acc_q;
			end
		end
	end

	assign res_out.valid  = out_valid_q;
	assign res_out.value  = out_value_q;
	assign res_out.status = out_status_q;

endmodule

// ----- rtl/atoi_any_base_parser_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atoi_any_base_parser_top
// Converts a byte stream to a signed 32-bit integer in a configurable base.
//
// char_in: one character per beat; the zero byte ends a string and gives
//   exactly one beat on res_out (value and status). Other characters give none.
// cfg: register writes (index 0/1: alphabet symbols, index 2: radix), always
//   ready; write only while no string is in flight.
// Throughput: one character per cycle while res_out does not stall, set by the
//   single back-stage multiply-add. Zero byte path: queue, then result register.
// A four-entry queue separates the classifying front from the parse stage,
//   and a result register lets characters keep flowing while a result waits.
// When res_out stalls, a second zero byte waits in the queue and char_in
//   drops ready once the queue fills.
// Reset: parse state cleared, alphabet "0123456789", radix 10.
// ----------------------------------------------------------------------------
module atoi_any_base_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	aapb_ch_if.sink     char_in,
	aapb_res_if.source  res_out,
	aapb_cfg_if.sink    cfg
);
	import aapb_pkg::*;

	cfg_t cfg_w;
	tok_t front_tok;
	tok_t back_tok;
	logic push;
	logic pop;
	logic full;
	logic empty;

	aapb_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cfg_o  (cfg_w)
	);

	aapb_front u_front (
		.char_in (char_in),
		.cfg_i   (cfg_w),
		.full_i  (full),
		.push_o  (push),
		.tok_o   (front_tok)
	);

	aapb_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push_i  (push),
		.tok_i   (front_tok),
		.full_o  (full),
		.pop_i   (pop),
		.tok_o   (back_tok),
		.empty_o (empty)
	);

	aapb_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_i   (cfg_w),
		.tok_i   (back_tok),
		.empty_i (empty),
		.pop_o   (pop),
		.res_out (res_out)
	);

endmodule
